// File: hdl/tty_line_discipline_unit_macros.svh
// Assertion helpers for the line discipline datapath.
`ifndef TTY_LINE_DISCIPLINE_UNIT_MACROS_SVH
`define TTY_LINE_DISCIPLINE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tld_pkg.sv
package tld_pkg;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_RECV = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_XMIT = 2'd2;

  // Echo kinds.
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_BYTE  = 3'd1;
  localparam logic [2:0] KIND_CRLF  = 3'd2;
  localparam logic [2:0] KIND_ERASE = 3'd3;
  localparam logic [2:0] KIND_NL    = 3'd4;

  // Read status codes.
  localparam logic [1:0] RS_OK        = 2'd0;
  localparam logic [1:0] RS_NOT_READY = 2'd1;
  localparam logic [1:0] RS_EOF       = 2'd2;

  // Bit positions in mode_flags.
  localparam int F_STRIP  = 0;
  localparam int F_IGNCR  = 1;
  localparam int F_ICRNL  = 2;
  localparam int F_INLCR  = 3;
  localparam int F_ICANON = 4;
  localparam int F_ECHO   = 5;
  localparam int F_ECHOE  = 6;
  localparam int F_ECHOK  = 7;
  localparam int F_ECHONL = 8;
  localparam int F_OPOST  = 9;
  localparam int F_ONLCR  = 10;

  // Register indexes.
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_ERASE = 3'd1;
  localparam logic [2:0] REG_KILL  = 3'd2;
  localparam logic [2:0] REG_WERASE = 3'd3;
  localparam logic [2:0] REG_EOF   = 3'd4;
  localparam logic [2:0] REG_EOL1  = 3'd5;
  localparam logic [2:0] REG_EOL2  = 3'd6;

  localparam logic [10:0] MODE_RESET = 11'd1780;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [8:0] COUNT_MAX = 9'h1FF;

  typedef struct packed {
    logic [10:0] mode;
    logic [7:0]  erase_ch;
    logic [7:0]  kill_ch;
    logic [7:0]  werase_ch;
    logic [7:0]  eof_ch;
    logic [7:0]  eol1_ch;
    logic [7:0]  eol2_ch;
  } cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] obyte;
    logic [8:0] ecount;
    logic [7:0] rbyte;
    logic [1:0] rstat;
    logic       lend;
    logic       full;
    logic       wake;
  } res_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic rd_fin;
    logic we_step;
  } cmd_t;

  typedef struct packed {
    logic need_rd;
    logic need_we;
    logic we_more;
  } stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_WE_WAIT
  } state_t;

  function automatic logic is_line_end(input logic [7:0] c, input logic [7:0] e1,
                                       input logic [7:0] e2);
    return (c == CH_NL) || (c == CH_CR) || ((e1 != 8'd0) && (c == e1)) ||
           ((e2 != 8'd0) && (c == e2));
  endfunction

endpackage

// File: hdl/tld_ram.sv
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/tld_ctrl.sv
module tld_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  tld_pkg::stat_t st,
  output tld_pkg::cmd_t  cmd,
  output logic           busy
);

  tld_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tld_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tld_pkg::ST_IDLE: begin
        if (start) state_nxt = tld_pkg::ST_EXEC;
      end
      tld_pkg::ST_EXEC: begin
        if (st.need_we) state_nxt = tld_pkg::ST_WE_WAIT;
        else if (st.need_rd) state_nxt = tld_pkg::ST_RD_WAIT;
        else state_nxt = tld_pkg::ST_IDLE;
      end
      tld_pkg::ST_RD_WAIT: state_nxt = tld_pkg::ST_IDLE;
      tld_pkg::ST_WE_WAIT: begin
        if (!st.we_more) state_nxt = tld_pkg::ST_IDLE;
      end
      default: state_nxt = tld_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      tld_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      tld_pkg::ST_EXEC:    cmd.exec    = 1'b1;
      tld_pkg::ST_RD_WAIT: cmd.rd_fin  = 1'b1;
      tld_pkg::ST_WE_WAIT: cmd.we_step = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// File: hdl/tld_datapath.sv
`include "tty_line_discipline_unit_macros.svh"

module tld_datapath #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tld_pkg::cfg_t  cfg,
  input  tld_pkg::cmd_t  cmd,
  output tld_pkg::stat_t st,
  input  logic [1:0]     in_operation,
  input  logic [7:0]     in_byte,
  input  logic           in_batch_end,
  output logic           res_vld,
  output tld_pkg::res_t  res
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(BUFFER_DEPTH - 1);
  localparam logic [CW-1:0] FILL_MAX = CW'(BUFFER_DEPTH);

  function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  logic [1:0]    op_r, op_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          last_r, last_nxt;
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [8:0]    line_r, line_nxt;
  logic          eof_r, eof_nxt;
  logic          acc_r, acc_nxt;
  logic [8:0]    n_r, n_nxt;
  logic          phase_r, phase_nxt;
  logic          vld_r, vld_nxt;
  tld_pkg::res_t res_r, res_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [7:0] c_s, c;
  logic       ignored, canon, echo_e, fill_zero, rd_ready;
  logic       h_erase, h_kill, h_word, h_eof;
  logic       we_sp, we_pop;
  logic       fin, rx_fin, w_en;
  logic [8:0] n_inc;

  tld_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (c),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Input mapping of the latched byte.
  always_comb begin
    c_s     = cfg.mode[tld_pkg::F_STRIP] ? {1'b0, byte_r[6:0]} : byte_r;
    ignored = cfg.mode[tld_pkg::F_IGNCR] && (c_s == tld_pkg::CH_CR);
    if (cfg.mode[tld_pkg::F_ICRNL] && (c_s == tld_pkg::CH_CR)) c = tld_pkg::CH_NL;
    else if (cfg.mode[tld_pkg::F_INLCR] && (c_s == tld_pkg::CH_NL)) c = tld_pkg::CH_CR;
    else c = c_s;
  end

  assign canon     = cfg.mode[tld_pkg::F_ICANON];
  assign echo_e    = cfg.mode[tld_pkg::F_ECHO] && cfg.mode[tld_pkg::F_ECHOE];
  assign fill_zero = (fill_r == '0);
  assign h_erase   = canon && (cfg.erase_ch != 8'd0) && (c == cfg.erase_ch);
  assign h_kill    = canon && (cfg.kill_ch != 8'd0) && (c == cfg.kill_ch);
  assign h_word    = canon && (cfg.werase_ch != 8'd0) && (c == cfg.werase_ch);
  assign h_eof     = canon && (cfg.eof_ch != 8'd0) && (c == cfg.eof_ch);
  assign rd_ready  = canon ? ((line_r != '0) || eof_r) : !fill_zero;

  assign st.need_we = (op_r == tld_pkg::OP_RECV) && !ignored && !h_erase && !h_kill &&
                      h_word && !fill_zero;
  assign st.need_rd = (op_r == tld_pkg::OP_READ) && rd_ready && !fill_zero;

  // Word erase walk: trailing spaces first, then the word itself.
  assign we_sp      = (ram_rdata == tld_pkg::CH_SPACE);
  assign we_pop     = !phase_r || !we_sp;
  assign st.we_more = we_pop && (fill_r != CW'(1));
  assign n_inc      = (n_r == tld_pkg::COUNT_MAX) ? n_r : n_r + 1'b1;

  always_comb begin
    op_nxt    = op_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    fill_nxt  = fill_r;
    line_nxt  = line_r;
    eof_nxt   = eof_r;
    acc_nxt   = acc_r;
    n_nxt     = n_r;
    phase_nxt = phase_r;
    res_nxt   = '0;
    ram_we    = 1'b0;
    ram_raddr = rp_r;
    fin       = 1'b0;
    rx_fin    = 1'b0;
    w_en      = 1'b0;

    if (cmd.latch) begin
      op_nxt   = in_operation;
      byte_nxt = in_byte;
      last_nxt = in_batch_end;
    end

    if (cmd.exec) begin
      case (op_r)
        tld_pkg::OP_RECV: begin
          fin    = !st.need_we;
          rx_fin = !st.need_we;
          if (!ignored) begin
            w_en = 1'b1;
            if (h_erase) begin
              if (!fill_zero) begin
                wp_nxt   = ptr_prev(wp_r);
                fill_nxt = fill_r - 1'b1;
                if (echo_e) begin
                  res_nxt.kind   = tld_pkg::KIND_ERASE;
                  res_nxt.ecount = 9'd1;
                end
              end
            end else if (h_kill) begin
              if (!fill_zero) begin
                wp_nxt   = rp_r;
                fill_nxt = '0;
                if (cfg.mode[tld_pkg::F_ECHO] && cfg.mode[tld_pkg::F_ECHOK])
                  res_nxt.kind = tld_pkg::KIND_NL;
              end
            end else if (h_word) begin
              n_nxt     = '0;
              phase_nxt = 1'b0;
              ram_raddr = ptr_prev(wp_r);
            end else if (h_eof) begin
              if (fill_zero) eof_nxt = 1'b1;
              else if (line_r != tld_pkg::COUNT_MAX) line_nxt = line_r + 1'b1;
            end else if (fill_r == FILL_MAX) begin
              res_nxt.full = 1'b1;
              w_en         = 1'b0;
            end else begin
              ram_we   = 1'b1;
              wp_nxt   = ptr_next(wp_r);
              fill_nxt = fill_r + 1'b1;
              if (canon && tld_pkg::is_line_end(c, cfg.eol1_ch, cfg.eol2_ch) &&
                  (line_r != tld_pkg::COUNT_MAX))
                line_nxt = line_r + 1'b1;
              if (cfg.mode[tld_pkg::F_ECHO] ||
                  (cfg.mode[tld_pkg::F_ECHONL] && (c == tld_pkg::CH_NL))) begin
                if (cfg.mode[tld_pkg::F_OPOST] && cfg.mode[tld_pkg::F_ONLCR] &&
                    (c == tld_pkg::CH_NL)) begin
                  res_nxt.kind = tld_pkg::KIND_CRLF;
                end else begin
                  res_nxt.kind  = tld_pkg::KIND_BYTE;
                  res_nxt.obyte = c;
                end
              end
            end
          end
        end
        tld_pkg::OP_READ: begin
          fin = !st.need_rd;
          if (!rd_ready) begin
            res_nxt.rstat = tld_pkg::RS_NOT_READY;
          end else if (canon && fill_zero && eof_r) begin
            eof_nxt       = 1'b0;
            res_nxt.rstat = tld_pkg::RS_EOF;
            if (line_r != '0) line_nxt = line_r - 1'b1;
          end else if (fill_zero) begin
            res_nxt.rstat = tld_pkg::RS_NOT_READY;
            if (line_r != '0) line_nxt = line_r - 1'b1;
          end
        end
        tld_pkg::OP_XMIT: begin
          fin = 1'b1;
          if (cfg.mode[tld_pkg::F_OPOST] && cfg.mode[tld_pkg::F_ONLCR] &&
              (byte_r == tld_pkg::CH_NL)) begin
            res_nxt.kind = tld_pkg::KIND_CRLF;
          end else begin
            res_nxt.kind  = tld_pkg::KIND_BYTE;
            res_nxt.obyte = byte_r;
          end
        end
        default: fin = 1'b1;
      endcase
    end

    if (cmd.rd_fin) begin
      fin           = 1'b1;
      res_nxt.rbyte = ram_rdata;
      rp_nxt        = ptr_next(rp_r);
      fill_nxt      = fill_r - 1'b1;
      if (canon && tld_pkg::is_line_end(ram_rdata, cfg.eol1_ch, cfg.eol2_ch)) begin
        res_nxt.lend = 1'b1;
        if (line_r != '0) line_nxt = line_r - 1'b1;
      end else if (canon && (fill_r == CW'(1)) && (line_r != '0)) begin
        line_nxt = line_r - 1'b1;
      end
    end

    if (cmd.we_step) begin
      phase_nxt = phase_r || !we_sp;
      if (we_pop) begin
        wp_nxt    = ptr_prev(wp_r);
        fill_nxt  = fill_r - 1'b1;
        n_nxt     = n_inc;
        ram_raddr = ptr_prev(ptr_prev(wp_r));
      end
      if (!st.we_more) begin
        fin    = 1'b1;
        rx_fin = 1'b1;
        w_en   = 1'b1;
        if (echo_e && (n_nxt != '0)) begin
          res_nxt.kind   = tld_pkg::KIND_ERASE;
          res_nxt.ecount = n_nxt;
        end
      end
    end

    // Wake is gathered over a receive batch and reported on its last beat.
    if (rx_fin) begin
      acc_nxt = acc_r || (w_en && (!canon || (line_nxt != '0) || eof_nxt));
      if (last_r) begin
        res_nxt.wake = acc_nxt;
        acc_nxt      = 1'b0;
      end
    end

    vld_nxt = fin;
    if (!fin) res_nxt = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      fill_r  <= '0;
      line_r  <= '0;
      eof_r   <= 1'b0;
      acc_r   <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      fill_r  <= fill_nxt;
      line_r  <= line_nxt;
      eof_r   <= eof_nxt;
      acc_r   <= acc_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
    n_r     <= n_nxt;
    phase_r <= phase_nxt;
    res_r   <= res_nxt;
  end

  assign res_vld = vld_r;
  assign res     = res_r;

  `TLD_ASSERT_SAME(a_fill_bound, 1'b1, fill_r <= FILL_MAX, "ring fill beyond depth")
  `TLD_ASSERT_SAME(a_empty_ptrs, fill_r == '0, wp_r == rp_r, "empty ring with apart pointers")
  `TLD_ASSERT_NEXT(a_one_result, vld_r, !vld_r, "results on consecutive cycles")
  `TLD_ASSERT_SAME(a_step_nonempty, cmd.we_step, fill_r != '0, "word erase on empty ring")

endmodule

// File: hdl/tty_line_discipline_unit.sv
// Channel   | Handshake                    | Payload
// input     | start / busy                 | in_operation, in_byte, in_batch_end
// result    | out_valid (one-cycle strobe) | out_kind .. out_wake
// config    | APB write/read, pready high  | paddr, pwdata, prdata
//
// A beat is taken at an edge where start is high and busy is low. The next
// cycle executes it; for most beats the result strobe follows in the cycle
// after that, during which busy is already low again. A read that pops a
// byte passes through an extra wait state, as the ring memory has a
// registered read port. A word erase stays in its wait state while it
// removes bytes and leaves when the walk stops at a space or an empty ring.
// Reset is synchronous and active low; the ring contents are not cleared and
// there is no clearing pass. The result receiver cannot stall the block.
module tty_line_discipline_unit #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_byte,
  input  logic        in_batch_end,
  // Result channel.
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [8:0]  out_erase_count,
  output logic [7:0]  out_read_byte,
  output logic [1:0]  out_read_status,
  output logic        out_line_end,
  output logic        out_buffer_full,
  output logic        out_wake,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tld_pkg::cfg_t  cfg_r, cfg_nxt;
  tld_pkg::cmd_t  cmd;
  tld_pkg::stat_t st;
  tld_pkg::res_t  res;
  logic           cfg_wr;
  logic [2:0]     cfg_idx;

  // Registers sit on word addresses; the low two address bits are ignored.
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        tld_pkg::REG_MODE:   cfg_nxt.mode      = pwdata[10:0];
        tld_pkg::REG_ERASE:  cfg_nxt.erase_ch  = pwdata[7:0];
        tld_pkg::REG_KILL:   cfg_nxt.kill_ch   = pwdata[7:0];
        tld_pkg::REG_WERASE: cfg_nxt.werase_ch = pwdata[7:0];
        tld_pkg::REG_EOF:    cfg_nxt.eof_ch    = pwdata[7:0];
        tld_pkg::REG_EOL1:   cfg_nxt.eol1_ch   = pwdata[7:0];
        tld_pkg::REG_EOL2:   cfg_nxt.eol2_ch   = pwdata[7:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tld_pkg::REG_MODE:   prdata = {21'd0, cfg_r.mode};
      tld_pkg::REG_ERASE:  prdata = {24'd0, cfg_r.erase_ch};
      tld_pkg::REG_KILL:   prdata = {24'd0, cfg_r.kill_ch};
      tld_pkg::REG_WERASE: prdata = {24'd0, cfg_r.werase_ch};
      tld_pkg::REG_EOF:    prdata = {24'd0, cfg_r.eof_ch};
      tld_pkg::REG_EOL1:   prdata = {24'd0, cfg_r.eol1_ch};
      tld_pkg::REG_EOL2:   prdata = {24'd0, cfg_r.eol2_ch};
      default:             prdata = 32'd0;
    endcase
  end

  // Reset values follow the usual canonical terminal defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= tld_pkg::MODE_RESET;
      cfg_r.erase_ch  <= 8'd127;
      cfg_r.kill_ch   <= 8'd21;
      cfg_r.werase_ch <= 8'd23;
      cfg_r.eof_ch    <= 8'd4;
      cfg_r.eol1_ch   <= 8'd0;
      cfg_r.eol2_ch   <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The controller sequences each beat; the datapath owns the ring and counters.
  tld_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  tld_datapath #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .cmd          (cmd),
    .st           (st),
    .in_operation (in_operation),
    .in_byte      (in_byte),
    .in_batch_end (in_batch_end),
    .res_vld      (out_valid),
    .res          (res)
  );

  assign out_kind        = res.kind;
  assign out_byte        = res.obyte;
  assign out_erase_count = res.ecount;
  assign out_read_byte   = res.rbyte;
  assign out_read_status = res.rstat;
  assign out_line_end    = res.lend;
  assign out_buffer_full = res.full;
  assign out_wake        = res.wake;

endmodule
